// ===== design/cdq_pkg.sv =====
// Shared definitions for the circular deque core: operation codes,
// register widths, defaults and the controller-to-datapath command bundle.
// No dependencies.
`default_nettype none

package cdq_pkg;

    localparam int DEPTH_DEFAULT     = 16;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic load;   // capture the incoming item
        logic exec;   // apply the operation, write the ring store
        logic read;   // read front and rear entries, latch flags
    } cmd_t;

endpackage

`default_nettype wire

// ===== design/cdq_ctrl.sv =====
// Controller for the circular deque core: sequences each item through
// execute, store read and result hold. Uses cdq_pkg.
`default_nettype none

module cdq_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    output cdq_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign cmd.load  = in_valid && (state_reg == ST_IDLE);
    assign cmd.exec  = (state_reg == ST_EXEC);
    assign cmd.read  = (state_reg == ST_READ);

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.exec, cmd.read}))
        else $error("more than one datapath command active");

    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted item not executed next cycle");

    a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |=> out_valid)
        else $error("result not offered after store read");

endmodule

`default_nettype wire

// ===== design/cdq_datapath.sv =====
// Datapath for the circular deque core: ring store, front/back indices,
// occupancy count, capacity register and result registers. Uses cdq_pkg.
`default_nettype none

module cdq_datapath #(
    parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cdq_pkg::cmd_t                cmd,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire logic [cdq_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [WORD_BITS-1:0]  value,
    output logic                              ok,
    output logic                              is_empty,
    output logic                              is_full,
    output logic                              front_valid,
    output logic signed [WORD_BITS-1:0]       front_word,
    output logic signed [WORD_BITS-1:0]       rear_word
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int UW = ((CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

    function automatic logic [IW-1:0] step_up(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] step_down(input logic [IW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    logic [WORD_BITS-1:0] ring_mem [DEPTH];

    logic [cdq_pkg::CAP_W-1:0]  cap_reg;
    logic [IW-1:0]              front_reg, front_next;
    logic [IW-1:0]              back_reg, back_next;
    logic [CW-1:0]              occ_reg, occ_next;
    logic [cdq_pkg::KIND_W-1:0] kind_reg;
    logic [WORD_BITS-1:0]       value_reg;
    logic                       ok_reg, ok_next;
    logic                       empty_reg, full_reg;
    logic [WORD_BITS-1:0]       front_q, rear_q;

    logic [UW-1:0] usable;
    logic [UW-1:0] cap_ext;
    logic          full_now;
    logic          empty_now;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    assign cap_ext   = UW'(cap_reg);
    assign usable    = (cap_ext > UW'(DEPTH)) ? UW'(DEPTH) : cap_ext;
    assign full_now  = (UW'(occ_reg) >= usable);
    assign empty_now = (occ_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        occ_next   = occ_reg;
        ok_next    = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = back_reg;
        case (kind_reg)
            cdq_pkg::KIND_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    front_next = step_down(front_reg);
                    wr_addr    = front_next;
                    wr_en      = 1'b1;
                    occ_next   = occ_reg + 1'b1;
                end
            end
            cdq_pkg::KIND_PUSH_BACK:
            begin
                if (full_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    wr_addr   = back_reg;
                    wr_en     = 1'b1;
                    back_next = step_up(back_reg);
                    occ_next  = occ_reg + 1'b1;
                end
            end
            cdq_pkg::KIND_POP_FRONT:
            begin
                if (empty_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    front_next = step_up(front_reg);
                    occ_next   = occ_reg - 1'b1;
                end
            end
            cdq_pkg::KIND_POP_BACK:
            begin
                if (empty_now)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    back_next = step_down(back_reg);
                    occ_next  = occ_reg - 1'b1;
                end
            end
            default: ok_next = 1'b1;   // query and unused codes change nothing
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= cdq_pkg::CAP_RESET;
            front_reg <= '0;
            back_reg  <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                front_reg <= front_next;
                back_reg  <= back_next;
                occ_reg   <= occ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= kind;
            value_reg <= value;
        end
        if (cmd.exec)
        begin
            ok_reg <= ok_next;
            if (wr_en)
            begin
                ring_mem[wr_addr] <= value_reg;
            end
        end
        if (cmd.read)
        begin
            front_q   <= ring_mem[front_reg];
            rear_q    <= ring_mem[step_down(back_reg)];
            empty_reg <= empty_now;
            full_reg  <= full_now;
        end
    end

    assign ok          = ok_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;
    assign front_valid = !empty_reg;
    assign front_word  = empty_reg ? '1 : front_q;
    assign rear_word   = empty_reg ? '1 : rear_q;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(DEPTH))
        else $error("occupancy above store depth");

    a_occ_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> $stable(occ_reg) && $stable(front_reg) && $stable(back_reg))
        else $error("deque state moved outside execute");

    a_refused_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && !ok_next |=> occ_reg == $past(occ_reg))
        else $error("refused operation changed occupancy");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> front_reg == back_reg)
        else $error("empty deque with mismatched indices");

endmodule

`default_nettype wire

// ===== design/circular_deque_core.sv =====
// Circular deque core: a bounded double-ended queue of signed words in a
// DEPTH-entry ring store. Each accepted item (push front, push back, pop
// front, pop back, or query) returns one result with the success flag,
// empty/full flags and the front and rear words (-1 when empty). One item
// is in flight at a time: the item passes the execute, store read and
// result hold states of the controller, and the next item is taken only
// after the result leaves. Execute updates the indices and writes the
// store; the read of the front and rear entries is registered.
// Capacity is written through cfg_wr_en/cfg_wr_data; the user must do
// so only while idle, as the block itself does not enforce it. Values
// above DEPTH act as DEPTH. No clearing pass is needed after reset.
`default_nettype none

module circular_deque_core #(
    parameter int DEPTH     = cdq_pkg::DEPTH_DEFAULT,
    parameter int WORD_BITS = cdq_pkg::WORD_BITS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cdq_pkg::CAP_W-1:0]    cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [cdq_pkg::KIND_W-1:0]   kind,
    input  wire logic signed [WORD_BITS-1:0]  value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              ok,
    output logic                              is_empty,
    output logic                              is_full,
    output logic                              front_valid,
    output logic signed [WORD_BITS-1:0]       front_word,
    output logic signed [WORD_BITS-1:0]       rear_word
);

    cdq_pkg::cmd_t cmd;

    cdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    cdq_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .kind        (kind),
        .value       (value),
        .ok          (ok),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .front_valid (front_valid),
        .front_word  (front_word),
        .rear_word   (rear_word)
    );

endmodule

`default_nettype wire
